// ----- src/cml_pkg.sv -----
// ----------------------------------------------------------------------------
// cml_pkg
// Shared types and constants of the C-minus scanner: scanner states, token
// kinds and the result records passed from the scan step to the result queue.
// ----------------------------------------------------------------------------
package cml_pkg;

   // Longest token text that is counted; longer tokens saturate here.
   localparam int MAX_TOKEN_LENGTH = 40;
   localparam int LEN_W            = 6;
   localparam int LINE_W           = 16;

   typedef enum logic [3:0] {
      ST_START        = 4'd0,
      ST_ASSIGN       = 4'd1,
      ST_SLASH        = 4'd2,
      ST_COMMENT      = 4'd3,
      ST_COMMENT_STAR = 4'd4,
      ST_NUM          = 4'd5,
      ST_ID           = 4'd6,
      ST_GT           = 4'd7,
      ST_LT           = 4'd8,
      ST_BANG         = 4'd9
   } scan_state_type;

   typedef enum logic [4:0] {
      TK_ENDFILE = 5'd0,
      TK_ERROR   = 5'd1,
      TK_IF      = 5'd2,
      TK_ELSE    = 5'd3,
      TK_WHILE   = 5'd4,
      TK_RETURN  = 5'd5,
      TK_VOID    = 5'd6,
      TK_INT     = 5'd7,
      TK_ID      = 5'd8,
      TK_NUM     = 5'd9,
      TK_ASSIGN  = 5'd10,
      TK_EQ      = 5'd11,
      TK_NOTEQ   = 5'd12,
      TK_LT      = 5'd13,
      TK_LE      = 5'd14,
      TK_GT      = 5'd15,
      TK_GE      = 5'd16,
      TK_PLUS    = 5'd17,
      TK_MINUS   = 5'd18,
      TK_TIMES   = 5'd19,
      TK_OVER    = 5'd20,
      TK_LPAREN  = 5'd21,
      TK_RPAREN  = 5'd22,
      TK_LSQ     = 5'd23,
      TK_RSQ     = 5'd24,
      TK_LCURL   = 5'd25,
      TK_RCURL   = 5'd26,
      TK_SEMI    = 5'd27,
      TK_COMMA   = 5'd28
   } token_kind_type;

   // One token result
   typedef struct packed {
      token_kind_type     kind;
      logic [LEN_W-1:0]   length;
      logic [LINE_W-1:0]  line;
      logic               last;
   } result_type;

   // Results produced by one character: count is 0, 1 or 2, res0 goes first
   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } step_out_type;

endpackage

// ----- src/cml_scan.sv -----
// ----------------------------------------------------------------------------
// cml_scan
// Scanner automaton state and one-character step. Closes a pending token and
// rescans the same character from the start state in the same cycle.
// ----------------------------------------------------------------------------
module cml_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            char_code,
   input  logic                  end_of_input,
   output cml_pkg::step_out_type step_out
);
   import cml_pkg::*;

   // Only the first few characters are kept: enough to spot a keyword
   localparam int KW_COUNT = 6;
   localparam int KW_SLOTS = 6;
   localparam int KW_IDX_W = $clog2(KW_SLOTS);

   localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_TOKEN_LENGTH);
   localparam logic [LEN_W-1:0] SLOTS_LEN = LEN_W'(KW_SLOTS);

   localparam logic [7:0] CH_EQ    = "=";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_STAR  = "*";
   localparam logic [7:0] CH_BANG  = "!";
   localparam logic [7:0] CH_LT    = "<";
   localparam logic [7:0] CH_GT    = ">";
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"e", "l", "s", "e", CH_NUL, CH_NUL},
      '{"w", "h", "i", "l", "e", CH_NUL},
      '{"r", "e", "t", "u", "r", "n"},
      '{"v", "o", "i", "d", CH_NUL, CH_NUL},
      '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL}
   };
   localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      LEN_W'(2), LEN_W'(4), LEN_W'(5), LEN_W'(6), LEN_W'(4), LEN_W'(3)
   };

   function automatic token_kind_type single_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         "+":     k = TK_PLUS;
         "-":     k = TK_MINUS;
         "*":     k = TK_TIMES;
         "(":     k = TK_LPAREN;
         ")":     k = TK_RPAREN;
         "[":     k = TK_LSQ;
         "]":     k = TK_RSQ;
         "{":     k = TK_LCURL;
         "}":     k = TK_RCURL;
         ";":     k = TK_SEMI;
         ",":     k = TK_COMMA;
         default: k = TK_ERROR;
      endcase
      return k;
   endfunction

   scan_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [7:0]         chars_ff [KW_SLOTS];
   logic [7:0]         chars_in [KW_SLOTS];
   logic [LINE_W-1:0]  line_ff, line_in;

   logic               is_digit, is_alpha, is_eq;
   scan_state_type     st_state;
   logic               st_save, st_emit;
   token_kind_type     st_kind;
   token_kind_type     kw_kind;
   logic               pend_v, rescan, save;
   token_kind_type     pend_kind;
   logic [LEN_W-1:0]   pend_len;
   logic               emit_start;
   result_type         pend_res, start_res;

   assign is_digit = (char_code >= "0") && (char_code <= "9");
   assign is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
                     ((char_code >= "A") && (char_code <= "Z"));
   assign is_eq    = !end_of_input && (char_code == CH_EQ);

   // Start-state decode of the current character
   always_comb begin
      st_state = ST_START;
      st_save  = 1'b0;
      st_emit  = 1'b0;
      st_kind  = TK_ENDFILE;
      priority if (end_of_input) begin
         st_emit = 1'b1;
      end else if (is_digit) begin
         st_save  = 1'b1;
         st_state = ST_NUM;
      end else if (is_alpha) begin
         st_save  = 1'b1;
         st_state = ST_ID;
      end else if (char_code == CH_EQ) begin
         st_state = ST_ASSIGN;
      end else if (char_code == CH_SLASH) begin
         st_state = ST_SLASH;
      end else if (char_code == CH_SPACE || char_code == CH_TAB || char_code == CH_LF) begin
         st_state = ST_START;
      end else if (char_code == CH_GT) begin
         st_state = ST_GT;
      end else if (char_code == CH_LT) begin
         st_state = ST_LT;
      end else if (char_code == CH_BANG) begin
         st_state = ST_BANG;
      end else begin
         st_emit = 1'b1;
         st_kind = single_kind(char_code);
      end
   end

   // Keyword lookup on the saved prefix
   always_comb begin
      logic match;
      kw_kind = TK_ID;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         match = (len_ff == KW_LEN[i]);
         for (int j = 0; j < KW_SLOTS; j++) begin
            if ((LEN_W'(j) < KW_LEN[i]) && (chars_ff[j] != KW_TEXT[i][j])) begin
               match = 1'b0;
            end
         end
         if (match) begin
            kw_kind = token_kind_type'(5'(TK_IF) + 5'(i));
         end
      end
   end

   // Automaton step
   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      chars_in  = chars_ff;
      pend_v    = 1'b0;
      pend_kind = TK_ERROR;
      pend_len  = '0;
      rescan    = 1'b0;
      save      = 1'b0;
      unique case (state_ff)
         ST_ASSIGN, ST_GT, ST_LT: begin
            pend_v = 1'b1;
            if (is_eq) begin
               pend_len = LEN_W'(2);
               state_in = ST_START;
               unique case (state_ff)
                  ST_ASSIGN: pend_kind = TK_EQ;
                  ST_GT:     pend_kind = TK_GE;
                  default:   pend_kind = TK_LE;
               endcase
            end else begin
               pend_len = LEN_W'(1);
               rescan   = 1'b1;
               unique case (state_ff)
                  ST_ASSIGN: pend_kind = TK_ASSIGN;
                  ST_GT:     pend_kind = TK_GT;
                  default:   pend_kind = TK_LT;
               endcase
            end
         end
         ST_SLASH: begin
            if (!end_of_input && char_code == CH_STAR) begin
               state_in = ST_COMMENT;
            end else begin
               pend_v    = 1'b1;
               pend_kind = TK_OVER;
               pend_len  = LEN_W'(1);
               rescan    = 1'b1;
            end
         end
         ST_COMMENT: begin
            if (end_of_input) begin
               pend_v    = 1'b1;
               pend_kind = TK_ENDFILE;
               state_in  = ST_START;
            end else if (char_code == CH_STAR) begin
               state_in = ST_COMMENT_STAR;
            end
         end
         ST_COMMENT_STAR: begin
            priority if (end_of_input) begin
               pend_v    = 1'b1;
               pend_kind = TK_ENDFILE;
               state_in  = ST_START;
            end else if (char_code == CH_STAR) begin
               state_in = ST_COMMENT_STAR;
            end else if (char_code == CH_SLASH) begin
               state_in = ST_START;
               len_in   = '0;
            end else begin
               state_in = ST_COMMENT;
            end
         end
         ST_BANG: begin
            pend_v = 1'b1;
            priority if (is_eq) begin
               pend_kind = TK_NOTEQ;
               pend_len  = LEN_W'(2);
               state_in  = ST_START;
            end else if (end_of_input) begin
               pend_kind = TK_ERROR;
               pend_len  = LEN_W'(1);
               rescan    = 1'b1;
            end else begin
               // the second character is swallowed by the error token
               pend_kind = TK_ERROR;
               pend_len  = LEN_W'(2);
               state_in  = ST_START;
            end
         end
         ST_NUM: begin
            if (!end_of_input && is_digit) begin
               save = 1'b1;
            end else begin
               pend_v    = 1'b1;
               pend_kind = TK_NUM;
               pend_len  = len_ff;
               rescan    = 1'b1;
            end
         end
         ST_ID: begin
            if (!end_of_input && is_alpha) begin
               save = 1'b1;
            end else begin
               pend_v    = 1'b1;
               pend_kind = kw_kind;
               pend_len  = len_ff;
               rescan    = 1'b1;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // append to the token text, saturating
      if (save && (len_ff < MAX_LEN)) begin
         if (len_ff < SLOTS_LEN) begin
            chars_in[len_ff[KW_IDX_W-1:0]] = char_code;
         end
         len_in = len_ff + LEN_W'(1);
      end

      // same character scanned again from the start state
      if (rescan) begin
         state_in = st_state;
         len_in   = st_save ? LEN_W'(1) : '0;
         if (st_save) begin
            chars_in[0] = char_code;
         end
      end
   end

   assign line_in = (!end_of_input && char_code == CH_LF) ? line_ff + LINE_W'(1) : line_ff;

   // Result assembly: pending token first, then the start-state token
   assign emit_start = rescan && st_emit;

   always_comb begin
      pend_res.kind    = pend_kind;
      pend_res.length  = pend_len;
      pend_res.line    = line_ff;
      pend_res.last    = !emit_start;
      start_res.kind   = st_kind;
      start_res.length = end_of_input ? '0 : LEN_W'(1);
      start_res.line   = line_ff;
      start_res.last   = 1'b1;

      step_out.res0  = pend_v ? pend_res : start_res;
      step_out.res1  = start_res;
      step_out.count = step_en ? (2'(pend_v) + 2'(emit_start)) : 2'd0;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         len_ff   <= '0;
         line_ff  <= LINE_W'(1);
      end else if (step_en) begin
         state_ff <= state_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
      end
   end

   // Saved token prefix, payload only
   always_ff @(posedge clock) begin
      if (step_en) begin
         chars_ff <= chars_in;
      end
   end

endmodule

// ----- src/cml_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// cml_rsp_queue
// Small result queue: takes up to two results per cycle from the scan step,
// hands them out one per cycle on the result channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module cml_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cml_pkg::step_out_type push,
   output logic                  push_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cml_pkg::result_type   rsp_data
);
   import cml_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop;

   // Room for the worst case of one character: two results
   assign push_ready = (count_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = entry_ff[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.res1;
      end
   end

endmodule

// ----- src/c_minus_lexer.sv -----
// ----------------------------------------------------------------------------
// c_minus_lexer
// C-minus scanner: one source character per item in, token items out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one character (req_char_code) per item, or an end-of-input
//   mark (req_end_of_input = 1, character ignored). rsp channel: one token
//   per item with kind, length (saturated), line and a flag on the last
//   token caused by a character. A character gives zero, one or two tokens.
//   A token caused by a character is written into the result queue when
//   the character is accepted; it shows on rsp once the tokens ahead of it
//   are taken. Throughput: one character per cycle while the result queue
//   has room for two tokens; the rsp side drains one token per cycle while
//   rsp_ready is high, so characters that yield two tokens set the pace to
//   one token per cycle on rsp; the four-entry result queue drives req_ready.
//   Reset: scanner in its start state, line counter at one, queue empty.
//   rsp stall: tokens collect in the queue; req_ready falls once fewer than
//   two entries are free and rises again as tokens are taken.
// ----------------------------------------------------------------------------
module c_minus_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [5:0]  rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_result
);
   import cml_pkg::*;

   logic          req_fire;
   step_out_type  step_out;
   result_type    rsp_data;

   assign req_fire = req_valid && req_ready;

   cml_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_fire),
      .char_code    (req_char_code),
      .end_of_input (req_end_of_input),
      .step_out     (step_out)
   );

   cml_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step_out),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_token_kind   = rsp_data.kind;
   assign rsp_token_length = rsp_data.length;
   assign rsp_line_number  = rsp_data.line;
   assign rsp_last_result  = rsp_data.last;

   // Results are only produced by an accepted character
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |-> step_out.count == 2'd0)
      else $error("results pushed without an accepted item");

   // Two results: only the second carries the last flag
   a_two_last: assert property (@(posedge clock) disable iff (reset)
      step_out.count == 2'd2 |-> !step_out.res0.last && step_out.res1.last)
      else $error("last flag misplaced on a two-result item");

   // Queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // End-of-file tokens carry no text
   a_endfile_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == TK_ENDFILE |-> rsp_token_length == '0)
      else $error("endfile token with nonzero length");

endmodule

// ----- sim/cml_token_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cml_token_checker
// Watches both channels of the C-minus scanner. Every accepted character is
// run through a local copy of the scanner automaton, and the tokens it yields
// are queued. Every accepted token is compared field by field against the
// oldest queued one. Mismatch and pending counts are handed to the top.
// ----------------------------------------------------------------------------
module cml_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_token_kind,
   input  logic [5:0]  rsp_token_length,
   input  logic [15:0] rsp_line_number,
   input  logic        rsp_last_result,
   output int          fail_count,
   output int          tokens_pending,
   output int          tokens_checked
);
   import cml_pkg::*;

   // Local scanner state
   scan_state_type     scan_st;
   logic [7:0]         word_buf [MAX_TOKEN_LENGTH];
   logic [LEN_W-1:0]   word_len;
   logic [LINE_W-1:0]  line_no;

   // Tokens of the current character, then the queue of tokens still owed
   result_type  step_tokens [2];
   int          step_count;
   result_type  owed_tokens [$];
   result_type  want;
   int          errors = 0;
   int          checked = 0;

   function automatic bit is_digit(logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   function automatic void add_token(token_kind_type kind, logic [LEN_W-1:0] len);
      result_type tok;
      if (step_count < 2) begin
         tok.kind   = kind;
         tok.length = len;
         tok.line   = line_no;
         tok.last   = 1'b0;
         step_tokens[step_count] = tok;
         step_count++;
      end
   endfunction

   // Text beyond the maximum is dropped, the length saturates
   function automatic void save_char(logic [7:0] ch);
      if (word_len < MAX_TOKEN_LENGTH) begin
         word_buf[word_len] = ch;
         word_len++;
      end
   endfunction

   // Scan a character from the start state
   function automatic void scan_from_start(logic [7:0] ch, logic eof);
      token_kind_type kind;
      scan_st  = ST_START;
      word_len = '0;
      if (eof) begin
         add_token(TK_ENDFILE, '0);
      end else if (is_digit(ch)) begin
         save_char(ch);
         scan_st = ST_NUM;
      end else if (is_letter(ch)) begin
         save_char(ch);
         scan_st = ST_ID;
      end else if (ch == "=") begin
         scan_st = ST_ASSIGN;
      end else if (ch == "/") begin
         scan_st = ST_SLASH;
      end else if (ch == " " || ch == "\t" || ch == "\n") begin
         scan_st = ST_START;
      end else if (ch == ">") begin
         scan_st = ST_GT;
      end else if (ch == "<") begin
         scan_st = ST_LT;
      end else if (ch == "!") begin
         scan_st = ST_BANG;
      end else begin
         case (ch)
            "+":     kind = TK_PLUS;
            "-":     kind = TK_MINUS;
            "*":     kind = TK_TIMES;
            "(":     kind = TK_LPAREN;
            ")":     kind = TK_RPAREN;
            "[":     kind = TK_LSQ;
            "]":     kind = TK_RSQ;
            "{":     kind = TK_LCURL;
            "}":     kind = TK_RCURL;
            ";":     kind = TK_SEMI;
            ",":     kind = TK_COMMA;
            default: kind = TK_ERROR;
         endcase
         add_token(kind, LEN_W'(1));
      end
   endfunction

   // One scanner step; queues the tokens this character yields
   function automatic void scan_char(logic [7:0] ch, logic eof);
      logic           is_eq;
      logic [47:0]    word;
      token_kind_type kind;
      int             i;
      is_eq = !eof && ch == "=";
      step_count = 0;
      case (scan_st)
         ST_ASSIGN: begin
            if (is_eq) begin
               add_token(TK_EQ, LEN_W'(2));
               scan_st = ST_START;
            end else begin
               add_token(TK_ASSIGN, LEN_W'(1));
               scan_from_start(ch, eof);
            end
         end
         ST_SLASH: begin
            if (!eof && ch == "*") begin
               scan_st = ST_COMMENT;
            end else begin
               add_token(TK_OVER, LEN_W'(1));
               scan_from_start(ch, eof);
            end
         end
         ST_COMMENT: begin
            if (eof) begin
               add_token(TK_ENDFILE, '0);
               scan_st = ST_START;
            end else if (ch == "*") begin
               scan_st = ST_COMMENT_STAR;
            end
         end
         ST_COMMENT_STAR: begin
            if (eof) begin
               add_token(TK_ENDFILE, '0);
               scan_st = ST_START;
            end else if (ch == "/") begin
               scan_st  = ST_START;
               word_len = '0;
            end else if (ch != "*") begin
               scan_st = ST_COMMENT;
            end
         end
         ST_GT: begin
            if (is_eq) begin
               add_token(TK_GE, LEN_W'(2));
               scan_st = ST_START;
            end else begin
               add_token(TK_GT, LEN_W'(1));
               scan_from_start(ch, eof);
            end
         end
         ST_LT: begin
            if (is_eq) begin
               add_token(TK_LE, LEN_W'(2));
               scan_st = ST_START;
            end else begin
               add_token(TK_LT, LEN_W'(1));
               scan_from_start(ch, eof);
            end
         end
         ST_BANG: begin
            if (is_eq) begin
               add_token(TK_NOTEQ, LEN_W'(2));
               scan_st = ST_START;
            end else if (eof) begin
               add_token(TK_ERROR, LEN_W'(1));
               scan_from_start(ch, eof);
            end else begin
               // the second character belongs to the error token
               add_token(TK_ERROR, LEN_W'(2));
               scan_st = ST_START;
            end
         end
         ST_NUM: begin
            if (!eof && is_digit(ch)) begin
               save_char(ch);
            end else begin
               add_token(TK_NUM, word_len);
               scan_from_start(ch, eof);
            end
         end
         ST_ID: begin
            if (!eof && is_letter(ch)) begin
               save_char(ch);
            end else begin
               // reserved words: pack the text, letters are never zero
               kind = TK_ID;
               if (word_len <= 6) begin
                  word = '0;
                  for (i = 0; i < word_len; i++) word = {word[39:0], word_buf[i]};
                  case (word)
                     "if":     kind = TK_IF;
                     "else":   kind = TK_ELSE;
                     "while":  kind = TK_WHILE;
                     "return": kind = TK_RETURN;
                     "void":   kind = TK_VOID;
                     "int":    kind = TK_INT;
                     default:  kind = TK_ID;
                  endcase
               end
               add_token(kind, word_len);
               scan_from_start(ch, eof);
            end
         end
         default: scan_from_start(ch, eof);
      endcase

      // newline counts after the tokens it closed, comments included
      if (!eof && ch == "\n") line_no = line_no + 1'b1;
      if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
      for (i = 0; i < step_count; i++) owed_tokens.push_back(step_tokens[i]);
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_val,
                                       logic [15:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
         errors++;
      end
   endfunction

   // Predict on accepted characters, compare accepted tokens
   always @(posedge clock) begin
      if (reset) begin
         scan_st  = ST_START;
         word_len = '0;
         line_no  = 16'd1;
         owed_tokens.delete();
      end else begin
         if (req_valid && req_ready) scan_char(req_char_code, req_end_of_input);
         if (rsp_valid && rsp_ready) begin
            if (owed_tokens.size() == 0) begin
               $error("token_kind: expected none, actual %0d (line %0d)",
                      rsp_token_kind, rsp_line_number);
               errors++;
            end else begin
               want = owed_tokens.pop_front();
               check_field("token_kind", 16'(want.kind), 16'(rsp_token_kind));
               check_field("token_length", 16'(want.length), 16'(rsp_token_length));
               check_field("line_number", want.line, rsp_line_number);
               check_field("last_result", 16'(want.last), 16'(rsp_last_result));
               checked++;
            end
         end
      end
      fail_count     <= errors;
      tokens_pending <= owed_tokens.size();
      tokens_checked <= checked;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the C-minus scanner a character stream: a short directed opening on
// operators, bang errors, comments, odd bytes and end of input, then random
// C-minus-like text with noise. Input comes in bursts, output stalls on its
// own pattern with one long hold-off; the checker beside the block judges.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_ITEMS   = 1650;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       eof;
      logic [7:0] code;
   } src_char_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_code;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_token_kind;
   logic [5:0]  rsp_token_length;
   logic [15:0] rsp_line_number;
   logic        rsp_last_result;
   int          fail_count;
   int          tokens_pending;
   int          tokens_checked;

   src_char_type src_q [$];
   int           items_sent = 0;
   int           eof_count = 0;
   int           cycles = 0;
   logic         hold_off = 1'b0;

   c_minus_lexer dut (.*);

   cml_token_checker token_chk (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void push_char(logic [7:0] c);
      src_q.push_back({1'b0, c});
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   // end-of-input mark; the character bits are junk
   function automatic void push_eof();
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      src_q.push_back({1'b1, junk});
      eof_count++;
   endfunction

   function automatic void push_name(int len);
      int r;
      repeat (len) begin
         r = $urandom_range(0, 51);
         push_char(8'((r < 26) ? ("a" + r) : ("A" + r - 26)));
      end
   endfunction

   // Stimulus and verdict
   initial begin : stimulus
      string        op_chars;
      string        space_chars;
      string        comment_chars;
      string        cut_chars;
      string        sep_chars;
      int           pick;
      int           burst;
      int           gap;
      src_char_type item;

      op_chars      = "+-*()[]{};,=<>/!";
      space_chars   = " \t\n";
      comment_chars = "*/\na *\n";
      cut_chars     = "!/<>=";
      sep_chars     = " \n\t;(,)";

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_char_code    <= 8'h00;
      req_end_of_input <= 1'b0;

      // directed opening
      push_text("!a!=<=>===");
      push_text("/**/");
      push_text("/");
      push_char(8'hFF);
      push_char(8'h00);
      push_text("=(");
      push_text("!");
      push_eof();
      push_text("/*");
      push_eof();
      push_eof();

      // random C-minus-like text, some noise and broken tokens
      while (src_q.size() < NUM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            case ($urandom_range(0, 5))
               0: push_text("if");
               1: push_text("else");
               2: push_text("while");
               3: push_text("return");
               4: push_text("void");
               default: push_text("int");
            endcase
            if ($urandom_range(0, 3) == 0) push_name(1);
         end else if (pick < 35) begin
            push_name(($urandom_range(0, 15) == 0) ? $urandom_range(36, 63)
                                                  : $urandom_range(1, 8));
         end else if (pick < 47) begin
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(36, 63)
                                                 : $urandom_range(1, 6))
               push_char(8'("0" + $urandom_range(0, 9)));
         end else if (pick < 62) begin
            if ($urandom_range(0, 1)) begin
               push_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
            end else begin
               case ($urandom_range(0, 3))
                  0: push_text("==");
                  1: push_text("<=");
                  2: push_text(">=");
                  default: push_text("!=");
               endcase
            end
         end else if (pick < 72) begin
            push_char(space_chars[$urandom_range(0, space_chars.len() - 1)]);
         end else if (pick < 80) begin
            // block comment, sometimes left open at end of input
            push_text("/*");
            repeat ($urandom_range(0, 12))
               push_char(comment_chars[$urandom_range(0, comment_chars.len() - 1)]);
            if ($urandom_range(0, 9) == 0) push_eof();
            else if ($urandom_range(0, 1)) push_text("*/");
            else push_text("**/");
         end else if (pick < 88) begin
            push_char(8'($urandom_range(0, 255)));
         end else if (pick < 91) begin
            push_eof();
         end else if (pick < 96) begin
            // operator prefix cut short by noise or end of input
            push_char(cut_chars[$urandom_range(0, cut_chars.len() - 1)]);
            if ($urandom_range(0, 3) == 0) push_eof();
            else push_char(8'($urandom_range(0, 255)));
         end else begin
            push_name($urandom_range(1, 5));
            push_eof();
         end
         if (pick < 47 && $urandom_range(0, 1))
            push_char(sep_chars[$urandom_range(0, sep_chars.len() - 1)]);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bursts of items with random gaps
      while (src_q.size() > 0) begin
         burst = $urandom_range(1, 40);
         gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         while (burst > 0 && src_q.size() > 0) begin
            item = src_q.pop_front();
            req_valid        <= 1'b1;
            req_char_code    <= item.code;
            req_end_of_input <= item.eof;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            items_sent++;
            burst--;
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // drain until no token is owed, then let the counts settle
      do @(posedge clock); while (tokens_pending != 0);
      repeat (8) @(posedge clock);

      $display("Scanned %0d characters (%0d end-of-input marks), compared %0d tokens",
               items_sent, eof_count, tokens_checked);
      $display("Keywords, long names and numbers, operators, comments and stray bytes, "
               , "under bursty input, output stalls and a long output hold-off");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Output side stalls on patterns that change after random spans
   initial begin : receiver
      int mode;
      int span;
      int n;
      n = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= !hold_off;
               1: rsp_ready <= !hold_off && ($urandom_range(0, 1) == 1);
               2: rsp_ready <= !hold_off && ($urandom_range(0, 4) == 0);
               default: rsp_ready <= !hold_off && (n % 3 != 0);
            endcase
            n++;
            @(posedge clock);
         end
      end
   end

   // Long hold-off on the output while input keeps coming, fills the queue
   initial begin : long_stall
      wait (items_sent >= 600);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d tokens still owed", cycles, tokens_pending);
         $display("Verification failed");
         $finish;
      end
   end

endmodule

// ----- files.f -----
src/cml_pkg.sv
src/cml_scan.sv
src/cml_rsp_queue.sv
src/c_minus_lexer.sv
sim/cml_token_checker.sv
sim/tb_top.sv
